// File: hw/rtl/mvma_pkg.sv
// Shared constants, configuration codes and the queue entry type for the
// matrix-vector multiply-accumulate block. No dependencies.
package mvma_pkg;

    localparam int MAX_COLS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int CNT_W    = $clog2(MAX_COLS + 1);

    localparam int DATA_W   = 16;
    localparam int ROW_W    = 16;
    localparam int NCOL_W   = 7;
    localparam int IDX_W    = 6;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int ACC_W    = 40;
    localparam int CFG_W    = 16;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QLVL_W   = $clog2(QDEPTH + 1);

    localparam int FRAC_SHIFT = 20;
    localparam int BETA_ALIGN = 8;
    localparam int Y_MAX      = 32767;
    localparam int Y_MIN      = -32768;

    localparam int ALPHA_RESET = 4096;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MAC  = 1'b1;

    typedef enum logic [1:0] {
        CFG_N_COLS,
        CFG_N_ROWS,
        CFG_ALPHA,
        CFG_BETA
    } t_cfg_idx;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic [DATA_W-1:0] y_old;
        logic              first;
        logic              last_col;
        logic [ROW_W-1:0]  row;
        logic              last_row;
    } t_mac_item;

endpackage

// File: hw/rtl/mvma_front.sv
// Front end: accepts items, writes the x store, tracks row and column position,
// reads x and forms each product. Depends on mvma_pkg.
module mvma_front import mvma_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_cmd,
    input  logic [IDX_W-1:0]         i_vec_index,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic signed [DATA_W-1:0] i_y_old,
    input  logic [NCOL_W-1:0]        i_n_cols,
    input  logic [ROW_W-1:0]         i_n_rows,
    input  logic [QLVL_W-1:0]        i_q_level,
    output logic                     o_item_valid,
    output t_mac_item                o_item
);

    logic [DATA_W-1:0] r_mem [MAX_COLS];
    logic [DATA_W-1:0] r_x;

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;

    logic              r_s1_valid;
    logic [DATA_W-1:0] r_s1_value;
    logic [DATA_W-1:0] r_s1_yold;
    logic              r_s1_first;
    logic              r_s1_last;
    logic [ROW_W-1:0]  r_s1_row;
    logic              r_s1_lastrow;

    logic              r_s2_valid;
    t_mac_item         r_s2_item;

    logic [QLVL_W:0]   busy;
    logic              accept;
    logic              is_load;
    logic              is_mac;
    logic              idx_ok;
    logic [CNT_W-1:0]  ncol_eff;
    logic [CNT_W-1:0]  col_inc;
    logic              last_col;
    logic [ROW_W-1:0]  last_row_pos;
    logic              row_last;

    assign busy = (QLVL_W + 1)'(i_q_level) + (QLVL_W + 1)'(r_s1_valid)
                + (QLVL_W + 1)'(r_s2_valid);
    assign o_in_stall = (busy >= (QLVL_W + 1)'(QDEPTH));
    assign accept  = i_in_valid && !o_in_stall;
    assign is_load = accept && (i_cmd == CMD_LOAD);
    assign is_mac  = accept && (i_cmd == CMD_MAC);
    assign idx_ok  = (32'(i_vec_index) < MAX_COLS);

    always_comb begin
        if (i_n_cols == '0) begin
            ncol_eff = CNT_W'(1);
        end else if (32'(i_n_cols) > MAX_COLS) begin
            ncol_eff = CNT_W'(MAX_COLS);
        end else begin
            ncol_eff = CNT_W'(i_n_cols);
        end
    end

    assign col_inc      = CNT_W'(r_col) + CNT_W'(1);
    assign last_col     = (col_inc >= ncol_eff);
    assign last_row_pos = i_n_rows - ROW_W'(1);
    assign row_last     = (r_row == last_row_pos);

    always_ff @(posedge i_clk) begin
        if (is_load && idx_ok) begin
            r_mem[COL_W'(i_vec_index)] <= i_value;
        end
        if (is_mac) begin
            r_x <= r_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= is_mac;
            r_s2_valid <= r_s1_valid;
            if (is_load) begin
                r_col <= '0;
                r_row <= '0;
            end else if (is_mac) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= COL_W'(col_inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_mac) begin
            r_s1_value   <= i_value;
            r_s1_yold    <= i_y_old;
            r_s1_first   <= (r_col == '0);
            r_s1_last    <= last_col;
            r_s1_row     <= r_row;
            r_s1_lastrow <= row_last;
        end
        r_s2_item.prod     <= PROD_W'($signed(r_s1_value) * $signed(r_x));
        r_s2_item.y_old    <= r_s1_yold;
        r_s2_item.first    <= r_s1_first;
        r_s2_item.last_col <= r_s1_last;
        r_s2_item.row      <= r_s1_row;
        r_s2_item.last_row <= r_s1_lastrow;
    end

    assign o_item_valid = r_s2_valid;
    assign o_item       = r_s2_item;

endmodule

// File: hw/rtl/mvma_queue.sv
// Short queue of products between the front end and the back end.
// Depends on mvma_pkg.
module mvma_queue import mvma_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_mac_item         i_push_item,
    input  logic              i_pop,
    output t_mac_item         o_item,
    output logic              o_empty,
    output logic [QLVL_W-1:0] o_level
);

    t_mac_item         r_buf [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QLVL_W-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + QLVL_W'(1);
            end else if (i_pop && !i_push) begin
                r_level <= r_level - QLVL_W'(1);
            end
        end
    end

    assign o_item  = r_buf[r_rd];
    assign o_empty = (r_level == '0);
    assign o_level = r_level;

endmodule

// File: hw/rtl/mvma_back.sv
// Back end: accumulates products per row, then scales, rescales and saturates
// each row result into the output register. Depends on mvma_pkg.
module mvma_back import mvma_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_item_valid,
    input  t_mac_item                i_item,
    output logic                     o_pop,
    input  logic signed [CFG_W-1:0]  i_alpha,
    input  logic signed [CFG_W-1:0]  i_beta,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_y_out,
    output logic [ROW_W-1:0]         o_row_index,
    output logic                     o_last_row
);

    localparam int PA_W  = ACC_W + CFG_W;
    localparam int PB_W  = CFG_W + DATA_W;
    localparam int SUM_W = PA_W + 1;

    logic signed [ACC_W-1:0]  r_acc;

    logic                     r_b_valid;
    logic signed [ACC_W-1:0]  r_b_acc;
    logic signed [DATA_W-1:0] r_b_yold;
    logic [ROW_W-1:0]         r_b_row;
    logic                     r_b_lastrow;

    logic                     r_c_valid;
    logic signed [PA_W-1:0]   r_c_pa;
    logic signed [PB_W-1:0]   r_c_pb;
    logic [ROW_W-1:0]         r_c_row;
    logic                     r_c_lastrow;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_y;
    logic [ROW_W-1:0]         r_out_row;
    logic                     r_out_lastrow;

    logic                     en;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [SUM_W-1:0]  sum_full;
    logic signed [SUM_W-1:0]  sum_shift;
    logic signed [DATA_W-1:0] y_sat;

    assign en    = !r_out_valid || !i_out_stall;
    assign o_pop = en && i_item_valid;

    assign acc_sum = (i_item.first ? ACC_W'(0) : r_acc)
                   + ACC_W'($signed(i_item.prod));

    assign sum_full  = SUM_W'(r_c_pa) + (SUM_W'(r_c_pb) <<< BETA_ALIGN);
    assign sum_shift = sum_full >>> FRAC_SHIFT;

    always_comb begin
        if (sum_shift > SUM_W'(Y_MAX)) begin
            y_sat = DATA_W'(Y_MAX);
        end else if (sum_shift < SUM_W'(Y_MIN)) begin
            y_sat = DATA_W'(Y_MIN);
        end else begin
            y_sat = DATA_W'(sum_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            if (o_pop) begin
                r_acc <= acc_sum;
            end
            r_b_valid   <= o_pop && i_item.last_col;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (o_pop && i_item.last_col) begin
                r_b_acc     <= acc_sum;
                r_b_yold    <= $signed(i_item.y_old);
                r_b_row     <= i_item.row;
                r_b_lastrow <= i_item.last_row;
            end
            r_c_pa        <= i_alpha * r_b_acc;
            r_c_pb        <= i_beta * r_b_yold;
            r_c_row       <= r_b_row;
            r_c_lastrow   <= r_b_lastrow;
            r_out_y       <= y_sat;
            r_out_row     <= r_c_row;
            r_out_lastrow <= r_c_lastrow;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_y_out     = r_out_y;
    assign o_row_index = r_out_row;
    assign o_last_row  = r_out_lastrow;

endmodule

// File: hw/rtl/matrix_vector_multiply_accumulate.sv
// Top level of the matrix-vector multiply-accumulate block: configuration
// registers, front end, product queue and back end. Depends on mvma_pkg.
//
// Usage: the block takes one input request per clock cycle in steady state,
// while input stall is low. A front pipeline (x store read, then one 16x16
// multiply) feeds a four-entry queue, and the back end accumulates one product
// per cycle while the output is not stalled and scales each finished row
// through two more register stages into the output register. Input stall
// rises when the queue plus the two front stages hold four products, which
// happens only once the output side has stalled. The x store has no reset and
// must be loaded before it is used; configuration must be written by the user
// only while no request is in flight, which the block itself does not enforce.
module matrix_vector_multiply_accumulate import mvma_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_cmd,
    input  logic [IDX_W-1:0]         i_vec_index,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic signed [DATA_W-1:0] i_y_old,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_y_out,
    output logic [ROW_W-1:0]         o_row_index,
    output logic                     o_last_row
);

    logic [NCOL_W-1:0]       r_n_cols;
    logic [ROW_W-1:0]        r_n_rows;
    logic signed [CFG_W-1:0] r_alpha;
    logic signed [CFG_W-1:0] r_beta;

    logic                    item_valid;
    t_mac_item               item;
    logic                    pop;
    t_mac_item               q_item;
    logic                    q_empty;
    logic [QLVL_W-1:0]       q_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_cols <= NCOL_W'(1);
            r_n_rows <= ROW_W'(1);
            r_alpha  <= CFG_W'(ALPHA_RESET);
            r_beta   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_N_COLS: r_n_cols <= i_cfg_data[NCOL_W-1:0];
                CFG_N_ROWS: r_n_rows <= i_cfg_data[ROW_W-1:0];
                CFG_ALPHA:  r_alpha  <= i_cfg_data;
                CFG_BETA:   r_beta   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mvma_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_vec_index  (i_vec_index),
        .i_value      (i_value),
        .i_y_old      (i_y_old),
        .i_n_cols     (r_n_cols),
        .i_n_rows     (r_n_rows),
        .i_q_level    (q_level),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    mvma_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (item_valid),
        .i_push_item (item),
        .i_pop       (pop),
        .o_item      (q_item),
        .o_empty     (q_empty),
        .o_level     (q_level)
    );

    mvma_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!q_empty),
        .i_item       (q_item),
        .o_pop        (pop),
        .i_alpha      (r_alpha),
        .i_beta       (r_beta),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_y_out      (o_y_out),
        .o_row_index  (o_row_index),
        .o_last_row   (o_last_row)
    );

endmodule

// File: hw/rtl/mvma_checker.sv
// Port-level checks for the matrix-vector multiply-accumulate block and the
// bind that attaches them to the top level. Depends on mvma_pkg.
module mvma_checker import mvma_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic signed [DATA_W-1:0] o_y_out,
    input logic [ROW_W-1:0]         o_row_index,
    input logic                     o_last_row
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid survived reset.");

    a_reset_opens_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("Input stalled right after reset.");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("Stalled result was dropped.");

    a_out_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_y_out) && $stable(o_row_index) && $stable(o_last_row))
        else $error("Stalled result changed.");

endmodule

bind matrix_vector_multiply_accumulate mvma_checker u_mvma_checker (.*);
